// ----- hw/rtl/u8v_pkg.sv -----
// Shared types, constants and byte checks for the UTF-8 stream validator.
package u8v_pkg;

  // Lead and continuation byte bounds
  localparam logic [7:0] ASCII_MAX   = 8'h7f;
  localparam logic [7:0] LEAD2_MIN   = 8'hc2;
  localparam logic [7:0] LEAD2_MAX   = 8'hdf;
  localparam logic [7:0] LEAD3_MIN   = 8'he0;
  localparam logic [7:0] LEAD3_MAX   = 8'hef;
  localparam logic [7:0] LEAD3_SURR  = 8'hed;
  localparam logic [7:0] LEAD4_MIN   = 8'hf0;
  localparam logic [7:0] LEAD4_MAX   = 8'hf4;
  localparam logic [7:0] CONT_MIN    = 8'h80;
  localparam logic [7:0] CONT_MAX    = 8'hbf;
  localparam logic [7:0] CONT_A0     = 8'ha0;
  localparam logic [7:0] CONT_9F     = 8'h9f;
  localparam logic [7:0] CONT_90     = 8'h90;
  localparam logic [7:0] CONT_8F     = 8'h8f;
  localparam logic [7:0] NUL_BYTE    = 8'h00;

  // Allowed range of the next continuation byte
  typedef enum logic [2:0] {
    CLS_ANY     = 3'd0,  // 80..BF
    CLS_NO_OVL3 = 3'd1,  // A0..BF after E0
    CLS_NO_SURR = 3'd2,  // 80..9F after ED
    CLS_NO_OVL4 = 3'd3,  // 90..BF after F0
    CLS_MAX_CP  = 3'd4   // 80..8F after F4
  } cont_class_t;

  // Per-string decoder state
  typedef struct packed {
    logic [1:0]  pending;
    cont_class_t cls;
    logic        err;
  } u8v_state_t;

  localparam u8v_state_t STATE_CLEAR = '{pending: 2'd0, cls: CLS_ANY, err: 1'b0};

  // Continuation byte range check for a given class
  function automatic logic cont_ok(input logic [7:0] b, input cont_class_t cls);
    logic ok;
    unique case (cls)
      CLS_NO_OVL3: ok = (b >= CONT_A0)  && (b <= CONT_MAX);
      CLS_NO_SURR: ok = (b >= CONT_MIN) && (b <= CONT_9F);
      CLS_NO_OVL4: ok = (b >= CONT_90)  && (b <= CONT_MAX);
      CLS_MAX_CP:  ok = (b >= CONT_MIN) && (b <= CONT_8F);
      default:     ok = (b >= CONT_MIN) && (b <= CONT_MAX);
    endcase
    return ok;
  endfunction

endpackage

// ----- hw/rtl/u8v_ifs.sv -----
// Valid/ready channel interfaces for the UTF-8 stream validator.
interface u8v_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_string;
  logic       empty_string;
  modport source (output valid, data_byte, end_of_string, empty_string, input ready);
  modport sink   (input valid, data_byte, end_of_string, empty_string, output ready);
endinterface

interface u8v_out_if;
  logic valid;
  logic ready;
  logic string_valid;
  modport source (output valid, string_valid, input ready);
  modport sink   (input valid, string_valid, output ready);
endinterface

interface u8v_cfg_if;
  logic valid;
  logic ready;
  logic data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ----- hw/rtl/utf8_stream_validator_unit.sv -----
// Top level of the UTF-8 stream validator: per-byte decode and string result.
//
//   channel   dir  payload                                   accepted when
//   in_item   in   data_byte[7:0], end_of_string, empty_str  valid && ready
//   out_item  out  string_valid                              valid && ready
//   cfg_wr    in   data (nul_allowed)                        valid && ready
//
// One byte item per cycle while in_item.ready is high; the decode state updates at the accept edge.
// A string result appears in the output register in the cycle after its last item is accepted.
// in_item.ready drops only while a result is held and out_item.ready is low.
// rst_n (synchronous) clears the decode state, the output valid and nul_allowed.
// cfg_wr is always ready.
module utf8_stream_validator_unit
  import u8v_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  u8v_in_if.sink     in_item,
  u8v_out_if.source  out_item,
  u8v_cfg_if.sink    cfg_wr
);

  logic       nul_allowed_r;
  u8v_state_t state_r, state_nxt;
  u8v_state_t step_st;
  logic       out_valid_r, out_valid_nxt;
  logic       string_valid_r, string_valid_nxt;
  logic       in_acc, closes;

  assign cfg_wr.ready   = 1'b1;
  assign in_item.ready  = !out_valid_r || out_item.ready;
  assign in_acc         = in_item.valid && in_item.ready;
  assign closes         = in_item.empty_string || in_item.end_of_string;
  assign out_item.valid = out_valid_r;
  assign out_item.string_valid = string_valid_r;

  // Decode of one byte against the current state
  always_comb begin
    step_st = state_r;
    if (!state_r.err) begin
      if (state_r.pending != 2'd0) begin
        if (!cont_ok(in_item.data_byte, state_r.cls)) begin
          step_st.err = 1'b1;
        end else begin
          step_st.pending = state_r.pending - 2'd1;
          step_st.cls     = CLS_ANY;
        end
      end else if (in_item.data_byte <= ASCII_MAX) begin
        if (in_item.data_byte == NUL_BYTE && !nul_allowed_r) begin
          step_st.err = 1'b1;
        end
      end else if (in_item.data_byte >= LEAD2_MIN && in_item.data_byte <= LEAD2_MAX) begin
        step_st.pending = 2'd1;
        step_st.cls     = CLS_ANY;
      end else if (in_item.data_byte >= LEAD3_MIN && in_item.data_byte <= LEAD3_MAX) begin
        step_st.pending = 2'd2;
        priority if (in_item.data_byte == LEAD3_MIN)  step_st.cls = CLS_NO_OVL3;
        else if (in_item.data_byte == LEAD3_SURR)     step_st.cls = CLS_NO_SURR;
        else                                          step_st.cls = CLS_ANY;
      end else if (in_item.data_byte >= LEAD4_MIN && in_item.data_byte <= LEAD4_MAX) begin
        step_st.pending = 2'd3;
        priority if (in_item.data_byte == LEAD4_MIN)  step_st.cls = CLS_NO_OVL4;
        else if (in_item.data_byte == LEAD4_MAX)      step_st.cls = CLS_MAX_CP;
        else                                          step_st.cls = CLS_ANY;
      end else begin
        step_st.err = 1'b1;
      end
    end
  end

  // Next state and result register loading
  always_comb begin
    u8v_state_t fin;
    fin              = in_item.empty_string ? state_r : step_st;
    state_nxt        = state_r;
    out_valid_nxt    = out_valid_r && !out_item.ready;
    string_valid_nxt = string_valid_r;
    if (in_acc) begin
      if (closes) begin
        state_nxt        = STATE_CLEAR;
        out_valid_nxt    = 1'b1;
        string_valid_nxt = !fin.err && (fin.pending == 2'd0);
      end else begin
        state_nxt = step_st;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= STATE_CLEAR;
      out_valid_r   <= 1'b0;
      nul_allowed_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr.valid) begin
        nul_allowed_r <= cfg_wr.data;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    string_valid_r <= string_valid_nxt;
  end

endmodule

// ----- hw/rtl/u8v_checker.sv -----
// Port-level checker for the UTF-8 stream validator, bound to the top level.
module u8v_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic in_end,
  input logic in_empty,
  input logic out_valid,
  input logic out_ready,
  input logic out_string_valid
);

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // A closing item always yields a result in the next cycle
  a_close_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_end || in_empty)) |=> out_valid)
    else $error("closing item gave no result");

  // A fresh result only follows an accepted closing item
  a_no_invented_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_acc && (in_end || in_empty)))
    else $error("result without closing item");

  // Input side is never stalled when no result is held
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

  // A stalled result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_string_valid)))
    else $error("stalled result changed");

endmodule

bind utf8_stream_validator_unit u8v_checker u_u8v_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_item.valid),
  .in_ready         (in_item.ready),
  .in_end           (in_item.end_of_string),
  .in_empty         (in_item.empty_string),
  .out_valid        (out_item.valid),
  .out_ready        (out_item.ready),
  .out_string_valid (out_item.string_valid)
);
